@@ hw/rtl/cwac_pkg.sv @@
// Shared definitions for the chinese-wall access checker.
// Holds field widths, op and register codes, parameter defaults and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps

package cwac_pkg;

  // Parameter defaults
  localparam int SUBJECTS_DEF  = 8;
  localparam int OBJECTS_DEF   = 16;
  localparam int COMPANIES_DEF = 16;

  // Field widths fixed by the request format
  localparam int OP_W      = 2;
  localparam int SUBJECT_W = 3;
  localparam int OBJECT_W  = 4;
  localparam int NIBBLE_W  = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COMPANY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPANY_CLASS  = 1'd1;

  // Request op codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // Conflict class that never conflicts
  localparam logic [NIBBLE_W-1:0] NO_CLASS = 4'd15;

  typedef struct packed {
    logic load;    // capture the incoming request
    logic commit;  // decide, update history and load the response
  } cwac_cmd_t;

endpackage

@@ hw/rtl/chinese_wall_access_checker_unit.sv @@
// Top level of the chinese-wall access checker.
// Joins cwac_ctrl and cwac_datapath; depends on cwac_pkg.
//
//   channel   handshake              payload
//   request   req_valid / req_ready  op, subject, object
//   response  rsp_valid / rsp_ready  granted
//   config    cfg_we                 cfg_index, cfg_data (no read-back)
//
// A request is handled in two steps: capture, then commit, which reads the
// subject's history row, runs the compare and priority pick over all objects,
// updates the marks and loads the response register. The next request is
// taken in the cycle after commit, even while the response still waits.
// A stalled response holds the commit of the following request.
// Reset (rst, synchronous) clears the maps and all read/write history.
`timescale 1ns / 1ps

module chinese_wall_access_checker_unit #(
  parameter int SUBJECTS  = cwac_pkg::SUBJECTS_DEF,
  parameter int OBJECTS   = cwac_pkg::OBJECTS_DEF,
  parameter int COMPANIES = cwac_pkg::COMPANIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [cwac_pkg::OP_W-1:0]       op,
  input  logic [cwac_pkg::SUBJECT_W-1:0]  subject,
  input  logic [cwac_pkg::OBJECT_W-1:0]   object,
  // response channel
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic                            granted,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [cwac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwac_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Commands from the controller into the datapath
  cwac_pkg::cwac_cmd_t cmd;

  // Sequence each request: capture, then commit once the response slot frees
  cwac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // Hold maps and history; decide grant or deny
  cwac_datapath #(
    .SUBJECTS  (SUBJECTS),
    .OBJECTS   (OBJECTS),
    .COMPANIES (COMPANIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .subject   (subject),
    .object    (object),
    .granted   (granted)
  );

endmodule

@@ hw/rtl/cwac_datapath.sv @@
// Datapath of the chinese-wall access checker: request registers, map
// registers, per-subject read/write history and the access decision.
// Depends on cwac_pkg.
`timescale 1ns / 1ps

module cwac_datapath #(
  parameter int SUBJECTS  = cwac_pkg::SUBJECTS_DEF,
  parameter int OBJECTS   = cwac_pkg::OBJECTS_DEF,
  parameter int COMPANIES = cwac_pkg::COMPANIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cwac_pkg::cwac_cmd_t             cmd,
  input  logic                            cfg_we,
  input  logic [cwac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [cwac_pkg::OP_W-1:0]       op,
  input  logic [cwac_pkg::SUBJECT_W-1:0]  subject,
  input  logic [cwac_pkg::OBJECT_W-1:0]   object,
  output logic                            granted
);

  localparam int SubjW = (SUBJECTS > 1) ? $clog2(SUBJECTS) : 1;
  localparam int ObjW  = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;

  logic [cwac_pkg::CFG_DATA_W-1:0] object_company_map;
  logic [cwac_pkg::CFG_DATA_W-1:0] company_class_map;

  logic [cwac_pkg::OP_W-1:0]      req_op;
  logic [cwac_pkg::SUBJECT_W-1:0] req_subject;
  logic [cwac_pkg::OBJECT_W-1:0]  req_object;

  logic [OBJECTS-1:0] read_marks  [SUBJECTS];
  logic [OBJECTS-1:0] write_marks [SUBJECTS];

  logic [SubjW-1:0]              row_idx;
  logic [ObjW-1:0]               obj_idx;
  logic [OBJECTS-1:0]            touched;
  logic [OBJECTS-1:0]            set_mask;
  logic [cwac_pkg::NIBBLE_W-1:0] want_comp;
  logic [cwac_pkg::NIBBLE_W-1:0] want_class;
  logic                          deny;
  logic                          req_ok;
  logic                          allow;

  function automatic logic [cwac_pkg::NIBBLE_W-1:0] class_of(
    input logic [cwac_pkg::NIBBLE_W-1:0]   comp,
    input logic [cwac_pkg::CFG_DATA_W-1:0] cmap
  );
    logic [cwac_pkg::NIBBLE_W-1:0] cls;
    if (int'(comp) >= COMPANIES) begin
      cls = cwac_pkg::NO_CLASS;
    end else begin
      cls = cmap[{comp, 2'b00} +: cwac_pkg::NIBBLE_W];
    end
    return cls;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_company_map <= '0;
      company_class_map  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwac_pkg::CFG_OBJECT_COMPANY: object_company_map <= cfg_data;
        cwac_pkg::CFG_COMPANY_CLASS:  company_class_map  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op      <= op;
      req_subject <= subject;
      req_object  <= object;
    end
  end

  assign row_idx    = SubjW'(req_subject);
  assign obj_idx    = ObjW'(req_object);
  assign touched    = read_marks[row_idx] | write_marks[row_idx];
  assign set_mask   = OBJECTS'(1) << obj_idx;
  assign want_comp  = object_company_map[{req_object, 2'b00} +: cwac_pkg::NIBBLE_W];
  assign want_class = class_of(want_comp, company_class_map);

  // Scan earlier objects in index order; the first hit of either kind decides
  always_comb begin
    logic                          found;
    logic [cwac_pkg::NIBBLE_W-1:0] comp;
    logic [cwac_pkg::NIBBLE_W-1:0] cls;
    found = 1'b0;
    deny  = 1'b0;
    for (int k = 0; k < OBJECTS; k++) begin
      comp = object_company_map[k*cwac_pkg::NIBBLE_W +: cwac_pkg::NIBBLE_W];
      cls  = class_of(comp, company_class_map);
      if (!found && touched[k]) begin
        if (comp == want_comp) begin
          found = 1'b1;
        end else if (cls == want_class && cls != cwac_pkg::NO_CLASS) begin
          found = 1'b1;
          deny  = 1'b1;
        end
      end
    end
  end

  assign req_ok = (int'(req_subject) < SUBJECTS) && (int'(req_object) < OBJECTS) &&
                  (req_op == cwac_pkg::OP_READ || req_op == cwac_pkg::OP_WRITE);
  assign allow  = touched[obj_idx] || !deny;

  // History and response
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SUBJECTS; s++) begin
        read_marks[s]  <= '0;
        write_marks[s] <= '0;
      end
    end else if (cmd.commit) begin
      if (req_op == cwac_pkg::OP_CLEAR) begin
        for (int s = 0; s < SUBJECTS; s++) begin
          read_marks[s]  <= '0;
          write_marks[s] <= '0;
        end
      end else if (req_ok && allow) begin
        if (req_op == cwac_pkg::OP_READ) begin
          read_marks[row_idx] <= read_marks[row_idx] | set_mask;
        end else begin
          write_marks[row_idx] <= write_marks[row_idx] | set_mask;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted <= (req_op == cwac_pkg::OP_CLEAR) || (req_ok && allow);
    end
  end

endmodule

@@ hw/rtl/cwac_ctrl.sv @@
// Controller of the chinese-wall access checker: request/response handshake
// and sequencing of the datapath through load and commit commands.
// Depends on cwac_pkg.
`timescale 1ns / 1ps

module cwac_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cwac_pkg::cwac_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

  state_t state;

  assign req_ready  = (state == ST_IDLE);
  assign cmd.load   = req_valid && req_ready;
  // Commit only when the response slot is free or being drained
  assign cmd.commit = (state == ST_CHECK) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE:  if (cmd.load) state <= ST_CHECK;
        ST_CHECK: if (cmd.commit) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
